// ===== hw/rtl/efca_pkg.sv =====
// shared types and constants of the eta file column append block
`timescale 1ns / 1ps

package efca_pkg;

  // default sizes of the eta file
  localparam int DEF_ETA_DEPTH   = 65536;
  localparam int DEF_MAX_COLUMNS = 256;

  // item opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_ELEM  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_PIVOT = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;
  localparam logic [1:0] ERR_COLS  = 2'd3;

  // configuration register select (paddr bit 2)
  localparam logic REG_SKIP  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  // reset values of the configuration registers
  localparam logic        SKIP_RESET  = 1'b1;
  localparam logic [16:0] LIMIT_RESET = 17'd65536;

  // reciprocal division: 2^48 over a 32-bit magnitude, one quotient bit a cycle
  localparam int DIV_BITS = 49;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture the accepted item
    logic div_start;  // launch the reciprocal division
    logic mul_en;     // capture the scale product
    logic rnd_en;     // capture the rounded product
    logic commit;     // update state and load the result register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic start_go;   // offered item is a start that opens a column
    logic elem_go;    // offered item is an element of an open column range
    logic div_busy;   // division still running
    logic out_free;   // result register can take a new item
  } st_t;

endpackage

// ===== hw/rtl/efca_div.sv =====
// restoring divider for the reciprocal scale, one quotient bit per cycle
`timescale 1ns / 1ps

module efca_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [48:0] quotient
);
  import efca_pkg::*;

  localparam int CNTW = $clog2(DIV_BITS);

  logic            busy_r, busy_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [31:0]     rem_r, rem_nxt;
  logic [31:0]     dvs_r, dvs_nxt;
  logic [48:0]     qd_r, qd_nxt;
  logic [32:0]     trial;
  logic [32:0]     diff;
  logic            ge;

  // one shift and subtract step
  always_comb begin
    trial    = {rem_r, qd_r[48]};
    diff     = trial - {1'b0, dvs_r};
    ge       = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    qd_nxt   = qd_r;
    if (start) begin
      // dividend is 2^48 plus half the divisor for round to nearest
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      qd_nxt   = {1'b1, 48'd0} + 49'(divisor >> 1);
    end else if (busy_r) begin
      rem_nxt = ge ? diff[31:0] : trial[31:0];
      qd_nxt  = {qd_r[47:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(DIV_BITS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    qd_r  <= qd_nxt;
  end

  assign busy     = busy_r;
  assign quotient = qd_r;

endmodule

// ===== hw/rtl/efca_ctrl.sv =====
// controller state machine sequencing each item through the datapath
`timescale 1ns / 1ps

module efca_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  efca_pkg::st_t  st,
  output efca_pkg::cmd_t cmd
);
  import efca_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.load      = accept;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (st.start_go) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else if (st.elem_go) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_DIV: begin
        if (!st.div_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_RND;
      end
      S_RND: begin
        cmd.rnd_en = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/efca_dp.sv =====
// datapath: item registers, scale arithmetic, eta file state and stores
`timescale 1ns / 1ps

module efca_dp #(
  parameter int ETA_DEPTH   = efca_pkg::DEF_ETA_DEPTH,
  parameter int MAX_COLUMNS = efca_pkg::DEF_MAX_COLUMNS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  efca_pkg::cmd_t     cmd,
  output efca_pkg::st_t      st,
  input  logic               skip_zero_values,
  input  logic [16:0]        fill_limit,
  input  logic [1:0]         in_opcode,
  input  logic [9:0]         in_pivot_row,
  input  logic signed [31:0] in_pivot_value,
  input  logic [9:0]         in_row_index,
  input  logic signed [31:0] in_element_value,
  input  logic               in_is_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_entry_written,
  output logic [15:0]        out_entry_position,
  output logic [9:0]         out_row,
  output logic signed [31:0] out_value,
  output logic [7:0]         out_column_number,
  output logic [10:0]        out_column_terms,
  output logic               out_column_done,
  output logic               out_refactor_needed,
  output logic [1:0]         out_error_code
);
  import efca_pkg::*;

  localparam int FW   = $clog2(ETA_DEPTH + 1);
  localparam int AW   = $clog2(ETA_DEPTH);
  localparam int CW   = $clog2(MAX_COLUMNS + 1);
  localparam int CIW  = $clog2(MAX_COLUMNS);
  localparam int CMPW = (FW > 17) ? FW : 17;
  localparam logic [10:0] TERM_MAX = 11'd2047;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // latched item
  logic [1:0]         op_r;
  logic [9:0]         prow_r;
  logic signed [31:0] pval_r;
  logic [9:0]         row_r;
  logic signed [31:0] eval_r;
  logic               last_r;

  // eta file state
  logic signed [31:0] s_r, s_nxt;
  logic [9:0]         pivrow_r, pivrow_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic               flag_r, flag_nxt;

  // arithmetic stages
  logic [63:0]        prod_r;
  logic signed [31:0] rnd_r;
  logic [10:0]        cnt_rd_r;

  // result register
  logic               out_valid_r;
  logic               written_r;
  logic [15:0]        pos_r;
  logic [9:0]         orow_r;
  logic signed [31:0] oval_r;
  logic [7:0]         colnum_r;
  logic [10:0]        terms_r;
  logic               done_r;
  logic               refac_r;
  logic [1:0]         err_r;

  // stores
  logic [15:0] start_mem [MAX_COLUMNS];
  logic [9:0]  piv_mem   [MAX_COLUMNS];
  logic [10:0] cnt_mem   [MAX_COLUMNS];
  logic [9:0]  row_mem   [ETA_DEPTH];
  logic [31:0] val_mem   [ETA_DEPTH];

  logic               div_busy;
  logic [48:0]        quot;
  logic [31:0]        div_mag;
  logic [31:0]        mag_e, mag_s;
  logic [63:0]        rsum;
  logic [39:0]        rmag;
  logic               rneg;
  logic signed [31:0] rnd_val;
  logic signed [31:0] recip;
  logic signed [31:0] neg_s;
  logic signed [31:0] eta_val;
  logic               col_ok;
  logic               is_start, is_elem, is_clear;
  logic               st_ok, el_ok, want, full, do_store, close;
  logic [10:0]        terms;
  logic [1:0]         err;
  logic [CIW-1:0]     col_idx;
  logic               cnt_we;
  logic [10:0]        cnt_wd;

  assign col_ok  = col_r < CW'(MAX_COLUMNS);
  assign col_idx = col_r[CIW-1:0];

  // decode of the offered item for the controller
  assign st.start_go = (in_opcode == OP_START) && (in_pivot_value != '0) && col_ok;
  assign st.elem_go  = (in_opcode == OP_ELEM) && col_ok;
  assign st.div_busy = div_busy;
  assign st.out_free = !out_valid_r || out_ready;

  // reciprocal divider on the pivot magnitude
  assign div_mag = in_pivot_value[31] ? 32'(-in_pivot_value) : 32'(in_pivot_value);

  efca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .divisor  (div_mag),
    .busy     (div_busy),
    .quotient (quot)
  );

  // S = -(2^48 / pivot), saturated
  always_comb begin
    if (!pval_r[31]) begin
      recip = (quot >= 49'h0_8000_0000) ? Q_MIN : 32'(-quot[31:0]);
    end else begin
      recip = (quot > 49'h0_7FFF_FFFF) ? Q_MAX : quot[31:0];
    end
  end

  // operand magnitudes for the scale product
  assign mag_e = eval_r[31] ? 32'(-eval_r) : 32'(eval_r);
  assign mag_s = s_r[31] ? 32'(-s_r) : 32'(s_r);

  // round the product to nearest, ties away from zero, and saturate
  always_comb begin
    rsum = prod_r + 64'h80_0000;
    rmag = rsum[63:24];
    rneg = eval_r[31] ^ s_r[31];
    if (rneg) begin
      rnd_val = (rmag >= 40'h80_0000_00) ? Q_MIN : 32'(-rmag[31:0]);
    end else begin
      rnd_val = (rmag > 40'h7F_FFFF_FF) ? Q_MAX : rmag[31:0];
    end
  end

  // value on the pivot row is -S
  assign neg_s = (s_r == Q_MIN) ? Q_MAX : 32'(-s_r);

  // item outcome
  always_comb begin
    is_start = (op_r == OP_START);
    is_elem  = (op_r == OP_ELEM);
    is_clear = (op_r == OP_CLEAR);
    st_ok    = is_start && (pval_r != '0) && col_ok;
    el_ok    = is_elem && col_ok;
    want     = !(skip_zero_values && (eval_r == '0));
    full     = fill_r >= FW'(ETA_DEPTH);
    do_store = el_ok && want && !full;
    close    = el_ok && last_r;
    eta_val  = (row_r == pivrow_r) ? neg_s : rnd_r;
    if (!el_ok) begin
      terms = '0;
    end else if (do_store && (cnt_rd_r != TERM_MAX)) begin
      terms = cnt_rd_r + 11'd1;
    end else begin
      terms = cnt_rd_r;
    end
    err = ERR_OK;
    if (is_start) begin
      if (pval_r == '0) begin
        err = ERR_PIVOT;
      end else if (!col_ok) begin
        err = ERR_COLS;
      end
    end else if (is_elem) begin
      if (!col_ok) begin
        err = ERR_COLS;
      end else if (want && full) begin
        err = ERR_FULL;
      end
    end
  end

  // next eta file state
  always_comb begin
    s_nxt      = s_r;
    pivrow_nxt = pivrow_r;
    col_nxt    = col_r;
    fill_nxt   = fill_r + FW'(do_store);
    flag_nxt   = flag_r;
    if (st_ok) begin
      s_nxt      = recip;
      pivrow_nxt = prow_r;
    end
    if (close) begin
      col_nxt = col_r + 1'b1;
      if (CMPW'(fill_nxt) > CMPW'(fill_limit)) begin
        flag_nxt = 1'b1;
      end
    end
    if (is_clear) begin
      fill_nxt = '0;
      col_nxt  = '0;
      flag_nxt = 1'b0;
    end
  end

  // item capture and arithmetic stages
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      prow_r <= in_pivot_row;
      pval_r <= in_pivot_value;
      row_r  <= in_row_index;
      eval_r <= in_element_value;
      last_r <= in_is_last;
    end
    if (cmd.mul_en) begin
      prod_r <= mag_e * mag_s;
    end
    if (cmd.rnd_en) begin
      rnd_r <= rnd_val;
    end
  end

  // eta file control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r         <= '0;
      pivrow_r    <= '0;
      col_r       <= '0;
      fill_r      <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        s_r      <= s_nxt;
        pivrow_r <= pivrow_nxt;
        col_r    <= col_nxt;
        fill_r   <= fill_nxt;
        flag_r   <= flag_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      written_r <= do_store;
      pos_r     <= do_store ? 16'(fill_r) : '0;
      orow_r    <= do_store ? row_r : '0;
      oval_r    <= do_store ? eta_val : '0;
      colnum_r  <= 8'(col_r);
      terms_r   <= terms;
      done_r    <= close;
      refac_r   <= flag_nxt;
      err_r     <= err;
    end
  end

  // column tables: start and pivot row written when a column opens
  always_ff @(posedge clk) begin
    if (cmd.commit && st_ok) begin
      start_mem[col_idx] <= 16'(fill_r);
      piv_mem[col_idx]   <= prow_r;
    end
  end

  // term count table, read at item capture, written at commit
  assign cnt_we = cmd.commit && (st_ok || el_ok);
  assign cnt_wd = st_ok ? 11'd0 : terms;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[col_idx] <= cnt_wd;
    end
    if (cmd.load) begin
      cnt_rd_r <= cnt_mem[col_idx];
    end
  end

  // eta entry stores
  always_ff @(posedge clk) begin
    if (cmd.commit && do_store) begin
      row_mem[fill_r[AW-1:0]] <= row_r;
      val_mem[fill_r[AW-1:0]] <= eta_val;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_entry_written   = written_r;
  assign out_entry_position  = pos_r;
  assign out_row             = orow_r;
  assign out_value           = oval_r;
  assign out_column_number   = colnum_r;
  assign out_column_terms    = terms_r;
  assign out_column_done     = done_r;
  assign out_refactor_needed = refac_r;
  assign out_error_code      = err_r;

endmodule

// ===== hw/rtl/eta_file_column_append.sv =====
// top level: configuration registers, controller and datapath of the eta file append
`timescale 1ns / 1ps

// Appends one eta column of a product-form inverse per start/element sequence.
// Items are taken one at a time. An element item has capture, 32x32 magnitude
// multiply, round and saturate, and store and result; a clear or rejected item
// has capture and store and result; a start item has capture, the restoring
// divider that forms S = -1/pivot one quotient bit per cycle over 49 bits,
// and store and result. The result register frees the input side: the next
// item is taken while a result still waits on the output. Eta entries go to
// single-port stores at the fill pointer; the column tables hold start, pivot
// row and term count per column. Store contents are never cleared: a clear
// item resets the fill pointer, column counter and refactor flag only.
module eta_file_column_append #(
  parameter int ETA_DEPTH   = efca_pkg::DEF_ETA_DEPTH,
  parameter int MAX_COLUMNS = efca_pkg::DEF_MAX_COLUMNS
) (
  input  logic               clk,
  input  logic               rst_n,
  // item input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [9:0]         in_pivot_row,
  input  logic signed [31:0] in_pivot_value,
  input  logic [9:0]         in_row_index,
  input  logic signed [31:0] in_element_value,
  input  logic               in_is_last,
  // result output
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_entry_written,
  output logic [15:0]        out_entry_position,
  output logic [9:0]         out_row,
  output logic signed [31:0] out_value,
  output logic [7:0]         out_column_number,
  output logic [10:0]        out_column_terms,
  output logic               out_column_done,
  output logic               out_refactor_needed,
  output logic [1:0]         out_error_code,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import efca_pkg::*;

  logic        skip_r;
  logic [16:0] limit_r;
  logic        cfg_wr;
  cmd_t        cmd;
  st_t         st;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r  <= SKIP_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SKIP) begin
        skip_r <= pwdata[0];
      end else begin
        limit_r <= pwdata[16:0];
      end
    end
  end

  // register read
  always_comb begin
    case (paddr[2])
      REG_SKIP:  prdata = {31'd0, skip_r};
      REG_LIMIT: prdata = {15'd0, limit_r};
      default:   prdata = '0;
    endcase
  end

  efca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  efca_dp #(
    .ETA_DEPTH   (ETA_DEPTH),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .skip_zero_values    (skip_r),
    .fill_limit          (limit_r),
    .in_opcode           (in_opcode),
    .in_pivot_row        (in_pivot_row),
    .in_pivot_value      (in_pivot_value),
    .in_row_index        (in_row_index),
    .in_element_value    (in_element_value),
    .in_is_last          (in_is_last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_entry_written   (out_entry_written),
    .out_entry_position  (out_entry_position),
    .out_row             (out_row),
    .out_value           (out_value),
    .out_column_number   (out_column_number),
    .out_column_terms    (out_column_terms),
    .out_column_done     (out_column_done),
    .out_refactor_needed (out_refactor_needed),
    .out_error_code      (out_error_code)
  );

  // one item at a time: the cycle after an accept takes no item
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in flight");

  // a stored entry never carries an error
  a_store_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_written |-> out_error_code == ERR_OK)
    else $error("entry stored with an error code");

  // a stored entry counts in its column
  a_store_terms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_written |-> out_column_terms != 11'd0)
    else $error("entry stored with zero column terms");

  // only an element of an open column range closes a column
  a_close_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_column_done |->
      out_error_code != ERR_COLS && out_error_code != ERR_PIVOT)
    else $error("column closed by a rejected item");

endmodule
